>>> design/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg - shared definitions for the midpoint ellipse rasteriser
// Command codes, mirror quadrant codes and fixed scale factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mer_pkg;

   // command carried on the request tuser
   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // mirror quadrant of an emitted pixel
   typedef logic [1:0] quad_type;

   localparam quad_type QUAD_NN = 2'd0;   // (-x,-y)
   localparam quad_type QUAD_NP = 2'd1;   // (-x,+y)
   localparam quad_type QUAD_PN = 2'd2;   // (+x,-y)
   localparam quad_type QUAD_PP = 2'd3;   // (+x,+y)

   // factor applied to (a2 - b2) at the region switch
   localparam int SWITCH_SCALE = 3;

endpackage

>>> design/midpoint_ellipse_raster.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster - integer midpoint ellipse rasteriser
// Start beat: set-up after acceptance, no response beats. Step beat: four
// response beats (one per cycle when not stalled), then an update on the
// single shared multiplier before the next request.
// Step after the ellipse has finished: one empty response beat.
// Synchronous active-high reset; the block then reports a finished ellipse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midpoint_ellipse_raster #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   // center_x, center_y, radius_x, radius_y (lowest first), zero padded
   input  logic [8*((2*COORD_BITS+2*RADIUS_BITS+7)/8)-1:0] req_tdata,
   // command
   input  mer_pkg::cmd_type req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_x, pixel_y (lowest first), zero padded
   output logic [8*((2*COORD_BITS+7)/8)-1:0] rsp_tdata,
   // quadrant, pixel_valid (lowest first)
   output logic [2:0]       rsp_tuser,
   // last_pixel
   output logic             rsp_tlast
);

   import mer_pkg::*;

   localparam int RB     = RADIUS_BITS;
   localparam int CB     = COORD_BITS;
   localparam int IN_W   = 2*CB + 2*RB;
   localparam int OUT_W  = 2*CB;
   localparam int OUT_DW = 8*((OUT_W+7)/8);
   localparam int SQ_W   = 2*RB;
   localparam int MA_W   = SQ_W + 1;
   localparam int OFF_W  = RB + 2;
   localparam int PROD_W = MA_W + OFF_W;
   localparam int DEC_W  = 4*RB + 4;
   localparam int SUM_W  = ((CB > OFF_W) ? CB : OFF_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EMIT,
      S_EMPTY,
      S_ADVANCE,
      S_MUL_BX,
      S_MUL_AY,
      S_UPDATE,
      S_SQ_X,
      S_SQ_Y,
      S_AR,
      S_K3,
      S_K3_SAVE,
      S_SUM,
      S_SWITCH
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      region2_ff, region2_in;
   logic signed [OFF_W-1:0] offset_y_ff, offset_y_in;

   // payload and working registers
   logic signed [OFF_W-1:0]  offset_x_ff, offset_x_in;
   logic signed [CB-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [RB-1:0]            rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_W-1:0]          a2_ff, a2_in, b2_ff, b2_in;
   logic signed [DEC_W-1:0]  decision_ff, decision_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] p_bx_ff, p_bx_in, p_ay_ff, p_ay_in;
   logic signed [PROD_W-1:0] k3_ff, k3_in;
   logic signed [PROD_W:0]   sum_ff, sum_in;
   logic                     due_ff, due_in;
   logic                     diag_ff, diag_in;
   quad_type                 quad_ff, quad_in;
   logic [OUT_DW-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]               rsp_tuser_ff, rsp_tuser_in;
   logic                     rsp_tlast_ff, rsp_tlast_in;

   // shared multiplier
   logic signed [MA_W-1:0]   mul_a;
   logic signed [OFF_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;

   // beat building
   quad_type                 bq;
   logic signed [SUM_W-1:0]  x_ext, y_ext, cx_ext, cy_ext, px_sum, py_sum;
   logic                     px_fits, py_fits;
   logic [CB-1:0]            px_sat, py_sat;
   logic                     dec_le0, diag_now, x_steps, y_steps, final_step;

   // decision-width operands
   logic [DEC_W-1:0] a2_dec, b2_dec, prod_dec, k3_dec, sum_dec;
   logic [DEC_W-1:0] p1_sel_dec, p2_sel_dec, diff_dec, step_c_dec;

   // request fields
   logic signed [CB-1:0] req_cx, req_cy;
   logic [RB-1:0]        req_rx, req_ry;

   assign req_cx = req_tdata[CB-1:0];
   assign req_cy = req_tdata[2*CB-1:CB];
   assign req_rx = req_tdata[2*CB+RB-1:2*CB];
   assign req_ry = req_tdata[IN_W-1:2*CB+RB];

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // operand select for the multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQ_X: begin
            mul_a = $signed({{(MA_W-RB){1'b0}}, rx_ff});
            mul_b = $signed({2'b00, rx_ff});
         end
         S_SQ_Y: begin
            mul_a = $signed({{(MA_W-RB){1'b0}}, ry_ff});
            mul_b = $signed({2'b00, ry_ff});
         end
         S_AR: begin
            mul_a = $signed({1'b0, a2_ff});
            mul_b = $signed({2'b00, ry_ff});
         end
         S_K3: begin
            mul_a = $signed({1'b0, a2_ff}) - $signed({1'b0, b2_ff});
            mul_b = OFF_W'(SWITCH_SCALE);
         end
         S_MUL_BX: begin
            mul_a = $signed({1'b0, b2_ff});
            mul_b = offset_x_ff;
         end
         S_MUL_AY: begin
            mul_a = $signed({1'b0, a2_ff});
            mul_b = offset_y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // step direction from the current decision
   assign dec_le0    = decision_ff[DEC_W-1] | ~|decision_ff;
   assign diag_now   = region2_ff ? dec_le0 : ~dec_le0;
   assign x_steps    = ~region2_ff | diag_now;
   assign y_steps    = region2_ff | diag_now;
   assign final_step = y_steps && (offset_y_ff == '0);

   // mirrored pixel of the next beat, saturated to the coordinate range
   assign bq     = (state_ff == S_IDLE) ? QUAD_NN : quad_type'(quad_ff + 2'd1);
   assign x_ext  = {{(SUM_W-OFF_W){offset_x_ff[OFF_W-1]}}, offset_x_ff};
   assign y_ext  = {{(SUM_W-OFF_W){offset_y_ff[OFF_W-1]}}, offset_y_ff};
   assign cx_ext = {{(SUM_W-CB){cx_ff[CB-1]}}, cx_ff};
   assign cy_ext = {{(SUM_W-CB){cy_ff[CB-1]}}, cy_ff};
   assign px_sum = cx_ext + (bq[1] ? x_ext : -x_ext);
   assign py_sum = cy_ext + (bq[0] ? y_ext : -y_ext);
   assign px_fits = (&px_sum[SUM_W-1:CB-1]) | ~|px_sum[SUM_W-1:CB-1];
   assign py_fits = (&py_sum[SUM_W-1:CB-1]) | ~|py_sum[SUM_W-1:CB-1];
   assign px_sat = px_fits ? px_sum[CB-1:0]
                           : {px_sum[SUM_W-1], {(CB-1){~px_sum[SUM_W-1]}}};
   assign py_sat = py_fits ? py_sum[CB-1:0]
                           : {py_sum[SUM_W-1], {(CB-1){~py_sum[SUM_W-1]}}};

   // operands widened to the decision width
   assign a2_dec     = {{(DEC_W-SQ_W){1'b0}}, a2_ff};
   assign b2_dec     = {{(DEC_W-SQ_W){1'b0}}, b2_ff};
   assign prod_dec   = {{(DEC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign k3_dec     = {{(DEC_W-PROD_W){k3_ff[PROD_W-1]}}, k3_ff};
   assign sum_dec    = {{(DEC_W-PROD_W-1){sum_ff[PROD_W]}}, sum_ff};
   assign p1_sel_dec = (~region2_ff | diag_ff)
                       ? {{(DEC_W-PROD_W){p_bx_ff[PROD_W-1]}}, p_bx_ff} : '0;
   assign p2_sel_dec = (region2_ff | diag_ff) ? prod_dec : '0;
   assign diff_dec   = p1_sel_dec - p2_sel_dec;
   assign step_c_dec = region2_ff ? a2_dec : b2_dec;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      region2_in    = region2_ff;
      offset_y_in   = offset_y_ff;
      offset_x_in   = offset_x_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      decision_in   = decision_ff;
      prod_in       = mul_p;
      p_bx_in       = p_bx_ff;
      p_ay_in       = p_ay_ff;
      k3_in         = k3_ff;
      sum_in        = sum_ff;
      due_in        = due_ff;
      diag_in       = diag_ff;
      quad_in       = quad_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_START) begin
                  cx_in    = req_cx;
                  cy_in    = req_cy;
                  rx_in    = req_rx;
                  ry_in    = req_ry;
                  state_in = S_SQ_X;
               end else if (offset_y_ff[OFF_W-1]) begin
                  // finished ellipse: one empty beat
                  rsp_tdata_in  = '0;
                  rsp_tuser_in  = '0;
                  rsp_tlast_in  = 1'b0;
                  rsp_tvalid_in = 1'b1;
                  state_in      = S_EMPTY;
               end else begin
                  rsp_tdata_in  = {{(OUT_DW-OUT_W){1'b0}}, py_sat, px_sat};
                  rsp_tuser_in  = {1'b1, bq};
                  rsp_tlast_in  = 1'b0;
                  rsp_tvalid_in = 1'b1;
                  quad_in       = bq;
                  state_in      = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (quad_ff == QUAD_PP) begin
                  rsp_tvalid_in = 1'b0;
                  state_in      = S_ADVANCE;
               end else begin
                  rsp_tdata_in = {{(OUT_DW-OUT_W){1'b0}}, py_sat, px_sat};
                  rsp_tuser_in = {1'b1, bq};
                  rsp_tlast_in = (bq == QUAD_PP) && final_step;
                  quad_in      = bq;
               end
            end
         end
         S_EMPTY: begin
            if (rsp_tready) begin
               rsp_tvalid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         // move the offsets, remember which branch was taken
         S_ADVANCE: begin
            diag_in     = diag_now;
            offset_x_in = offset_x_ff + (x_steps ? OFF_W'(1) : OFF_W'(0));
            offset_y_in = offset_y_ff - (y_steps ? OFF_W'(1) : OFF_W'(0));
            state_in    = S_MUL_BX;
         end
         S_MUL_BX: begin
            state_in = S_MUL_AY;
         end
         S_MUL_AY: begin
            p_bx_in  = prod_ff;
            state_in = S_UPDATE;
         end
         // decision += 8*(selected b2*x - selected a2*y) + 4*(a2 or b2)
         S_UPDATE: begin
            p_ay_in     = prod_ff;
            decision_in = decision_ff + {diff_dec[DEC_W-4:0], 3'b000}
                          + {step_c_dec[DEC_W-3:0], 2'b00};
            state_in    = S_SUM;
         end
         S_SQ_X: begin
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            a2_in    = prod_ff[SQ_W-1:0];
            state_in = S_AR;
         end
         S_AR: begin
            b2_in    = prod_ff[SQ_W-1:0];
            state_in = S_K3;
         end
         // initial decision a2 + 4*(b2 - a2*ry), offsets at the top
         S_K3: begin
            p_ay_in     = prod_ff;
            p_bx_in     = '0;
            offset_x_in = '0;
            offset_y_in = {2'b00, ry_ff};
            decision_in = a2_dec + {b2_dec[DEC_W-3:0], 2'b00}
                          - {prod_dec[DEC_W-3:0], 2'b00};
            region2_in  = 1'b0;
            state_in    = S_K3_SAVE;
         end
         S_K3_SAVE: begin
            k3_in    = prod_ff;
            state_in = S_SUM;
         end
         // region test a2*y - b2*x <= 0
         S_SUM: begin
            sum_in   = {p_bx_ff[PROD_W-1], p_bx_ff} + {p_ay_ff[PROD_W-1], p_ay_ff};
            due_in   = ~region2_ff && (p_ay_ff <= p_bx_ff);
            state_in = S_SWITCH;
         end
         S_SWITCH: begin
            if (due_ff) begin
               decision_in = decision_ff + k3_dec - {sum_dec[DEC_W-3:0], 2'b00};
               region2_in  = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         region2_ff    <= 1'b0;
         offset_y_ff   <= '1;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         region2_ff    <= region2_in;
         offset_y_ff   <= offset_y_in;
      end
      offset_x_ff  <= offset_x_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      a2_ff        <= a2_in;
      b2_ff        <= b2_in;
      decision_ff  <= decision_in;
      prod_ff      <= prod_in;
      p_bx_ff      <= p_bx_in;
      p_ay_ff      <= p_ay_in;
      k3_ff        <= k3_in;
      sum_ff       <= sum_in;
      due_ff       <= due_in;
      diag_ff      <= diag_in;
      quad_ff      <= quad_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

`ifndef SYNTHESIS
   // no request is taken while a beat is still pending
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request accepted with a response beat pending");

   // the end mark only rides on a valid (+x,+y) pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2] && (rsp_tuser[1:0] == QUAD_PP))
      else $error("last pixel on the wrong beat");

   // pixel beats of one step come in quadrant order
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[2] && (rsp_tuser[1:0] != QUAD_PP)
      |=> rsp_tvalid && (rsp_tuser[1:0] == quad_type'($past(rsp_tuser[1:0]) + 2'd1)))
      else $error("quadrant sequence broken");

   // second region is only left by a new start
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(region2_ff) |-> $past(state_ff) == S_K3)
      else $error("region flag cleared outside start");

   // x offset stays non-negative while drawing
   assert property (@(posedge clock) disable iff (reset)
      !offset_y_ff[OFF_W-1] && (state_ff == S_EMIT) |-> !offset_x_ff[OFF_W-1])
      else $error("negative x offset while drawing");
`endif

endmodule
